>>> rtl/core/qafm_pkg.sv
// Shared widths, register codes, reset values and mixing signs of the attitude mixer.
`default_nettype none

package qafm_pkg;

   localparam int InW       = 16;
   localparam int ErrW      = InW + 1;
   localparam int GainW     = 16;
   localparam int BaseW     = 24;
   localparam int ProdW     = ErrW + GainW;
   localparam int RateShift = 2;
   localparam int AxW       = ProdW + RateShift + 1;
   localparam int BaseShift = 12;
   localparam int SumW      = 39;
   localparam int FracW     = 20;
   localparam int MotorW    = 16;
   localparam int NumErr    = 6;
   localparam int NumAxis   = 3;
   localparam int NumMotor  = 4;
   localparam int RegIdxW   = 3;
   localparam int CsrDataW  = 24;

   localparam logic [RegIdxW-1:0] RegGainRollAngle  = 3'd0;
   localparam logic [RegIdxW-1:0] RegGainPitchAngle = 3'd1;
   localparam logic [RegIdxW-1:0] RegGainYawAngle   = 3'd2;
   localparam logic [RegIdxW-1:0] RegGainRollRate   = 3'd3;
   localparam logic [RegIdxW-1:0] RegGainPitchRate  = 3'd4;
   localparam logic [RegIdxW-1:0] RegGainYawRate    = 3'd5;
   localparam logic [RegIdxW-1:0] RegBaseThrust     = 3'd6;

   localparam int ErrRollAngle  = 0;
   localparam int ErrPitchAngle = 1;
   localparam int ErrYawAngle   = 2;
   localparam int ErrRollRate   = 3;
   localparam int ErrPitchRate  = 4;
   localparam int ErrYawRate    = 5;

   localparam int AxRoll  = 0;
   localparam int AxPitch = 1;
   localparam int AxYaw   = 2;

   typedef logic [NumErr-1:0][ErrW-1:0]     err_vec_type;
   typedef logic [NumErr-1:0][ProdW-1:0]    prod_vec_type;
   typedef logic [NumAxis-1:0][AxW-1:0]     ax_vec_type;
   typedef logic [NumMotor-1:0][SumW-1:0]   sum_vec_type;
   typedef logic [NumMotor-1:0][MotorW-1:0] motor_vec_type;

   typedef struct packed {
      logic [NumErr-1:0][GainW-1:0] gain;
      logic [BaseW-1:0]             base_thrust;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      gain: {16'd4324, 16'd5626, 16'd4908, 16'd1256, 16'd35987, 16'd34582},
      base_thrust: 24'd7549747
   };

   // set bit: axis term added for that motor; angle and rate terms share a sign
   localparam logic [NumMotor-1:0][NumAxis-1:0] MixPlus = {
      3'b101, 3'b011, 3'b110, 3'b000
   };

endpackage

`default_nettype wire

>>> rtl/core/qafm_if.sv
// Handshake channel interfaces: sensor request, motor response and register write.
`default_nettype none

interface qafm_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [qafm_pkg::InW-1:0]  roll_ref;
   logic signed [qafm_pkg::InW-1:0]  pitch_ref;
   logic signed [qafm_pkg::InW-1:0]  yaw_rate_ref;
   logic signed [qafm_pkg::InW-1:0]  roll_angle;
   logic signed [qafm_pkg::InW-1:0]  pitch_angle;
   logic signed [qafm_pkg::InW-1:0]  yaw_angle;
   logic signed [qafm_pkg::InW-1:0]  roll_rate;
   logic signed [qafm_pkg::InW-1:0]  pitch_rate;
   logic signed [qafm_pkg::InW-1:0]  yaw_rate;

   modport source (
      output valid, roll_ref, pitch_ref, yaw_rate_ref, roll_angle, pitch_angle,
             yaw_angle, roll_rate, pitch_rate, yaw_rate,
      input  ready
   );
   modport sink (
      input  valid, roll_ref, pitch_ref, yaw_rate_ref, roll_angle, pitch_angle,
             yaw_angle, roll_rate, pitch_rate, yaw_rate,
      output ready
   );
endinterface

interface qafm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [qafm_pkg::MotorW-1:0]     motor_one;
   logic [qafm_pkg::MotorW-1:0]     motor_two;
   logic [qafm_pkg::MotorW-1:0]     motor_three;
   logic [qafm_pkg::MotorW-1:0]     motor_four;

   modport source (
      output valid, motor_one, motor_two, motor_three, motor_four,
      input  ready
   );
   modport sink (
      input  valid, motor_one, motor_two, motor_three, motor_four,
      output ready
   );
endinterface

interface qafm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [qafm_pkg::RegIdxW-1:0]    index;
   logic [qafm_pkg::CsrDataW-1:0]   data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/qafm_csr_regs.sv
// Gain and base thrust register file behind the write channel.
`default_nettype none

module qafm_csr_regs (
   input  wire logic        clock,
   input  wire logic        reset,
   qafm_csr_if.sink         csr,
   output qafm_pkg::cfg_type cfg
);

   qafm_pkg::cfg_type cfg_ff;
   qafm_pkg::cfg_type cfg_in;

   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid && csr.ready) begin
         unique case (csr.index) inside
            qafm_pkg::RegGainRollAngle, qafm_pkg::RegGainPitchAngle,
            qafm_pkg::RegGainYawAngle, qafm_pkg::RegGainRollRate,
            qafm_pkg::RegGainPitchRate, qafm_pkg::RegGainYawRate: begin
               cfg_in.gain[csr.index] = csr.data[qafm_pkg::GainW-1:0];
            end
            qafm_pkg::RegBaseThrust: begin
               cfg_in.base_thrust = csr.data[qafm_pkg::BaseW-1:0];
            end
            default: begin
               // drop writes past the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= qafm_pkg::CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/core/qafm_err_stage.sv
// Input stage: form and register the six attitude and rate errors.
`default_nettype none

module qafm_err_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   qafm_req_if.sink                   req,
   output logic                       err_valid,
   input  wire logic                  err_ready,
   output qafm_pkg::err_vec_type      err_data
);

   logic                  valid_ff;
   qafm_pkg::err_vec_type data_ff;
   qafm_pkg::err_vec_type data_in;
   logic                  load;

   assign req.ready = !valid_ff || err_ready;
   assign load      = req.valid && req.ready;

   always_comb begin
      data_in[qafm_pkg::ErrRollAngle]  = {req.roll_ref[qafm_pkg::InW-1], req.roll_ref}
                                       - {req.roll_angle[qafm_pkg::InW-1], req.roll_angle};
      data_in[qafm_pkg::ErrPitchAngle] = {req.pitch_ref[qafm_pkg::InW-1], req.pitch_ref}
                                       - {req.pitch_angle[qafm_pkg::InW-1], req.pitch_angle};
      data_in[qafm_pkg::ErrYawAngle]   = {qafm_pkg::ErrW{1'b0}}
                                       - {req.yaw_angle[qafm_pkg::InW-1], req.yaw_angle};
      data_in[qafm_pkg::ErrRollRate]   = {qafm_pkg::ErrW{1'b0}}
                                       - {req.roll_rate[qafm_pkg::InW-1], req.roll_rate};
      data_in[qafm_pkg::ErrPitchRate]  = {qafm_pkg::ErrW{1'b0}}
                                       - {req.pitch_rate[qafm_pkg::InW-1], req.pitch_rate};
      data_in[qafm_pkg::ErrYawRate]    = {req.yaw_rate_ref[qafm_pkg::InW-1], req.yaw_rate_ref}
                                       - {req.yaw_rate[qafm_pkg::InW-1], req.yaw_rate};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req.ready) begin
         valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign err_valid = valid_ff;
   assign err_data  = data_ff;

endmodule

`default_nettype wire

>>> rtl/core/qafm_mul_stage.sv
// Gain stage: six signed-by-unsigned products, registered.
`default_nettype none

module qafm_mul_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  err_valid,
   output logic                       err_ready,
   input  wire qafm_pkg::err_vec_type err_data,
   input  wire qafm_pkg::cfg_type     cfg,
   output logic                       prod_valid,
   input  wire logic                  prod_ready,
   output qafm_pkg::prod_vec_type     prod_data
);

   logic                   valid_ff;
   qafm_pkg::prod_vec_type data_ff;
   qafm_pkg::prod_vec_type data_in;
   logic signed [qafm_pkg::ProdW:0] full [qafm_pkg::NumErr];
   logic                   load;

   assign err_ready = !valid_ff || prod_ready;
   assign load      = err_valid && err_ready;

   for (genvar k = 0; k < qafm_pkg::NumErr; k++) begin : g_mul
      assign full[k]    = $signed(err_data[k]) * $signed({1'b0, cfg.gain[k]});
      assign data_in[k] = full[k][qafm_pkg::ProdW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (err_ready) begin
         valid_ff <= err_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign prod_valid = valid_ff;
   assign prod_data  = data_ff;

endmodule

`default_nettype wire

>>> rtl/core/qafm_mix_stage.sv
// Mixing stages: per-axis sums, per-motor signed sums with thrust, clamp to motor range.
`default_nettype none

module qafm_mix_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   prod_valid,
   output logic                        prod_ready,
   input  wire qafm_pkg::prod_vec_type prod_data,
   input  wire qafm_pkg::cfg_type      cfg,
   qafm_rsp_if.source                  rsp
);

   localparam int TopW = qafm_pkg::FracW + qafm_pkg::MotorW;

   logic                    ax_v_ff;
   qafm_pkg::ax_vec_type    ax_ff;
   qafm_pkg::ax_vec_type    ax_in;
   logic                    sum_v_ff;
   qafm_pkg::sum_vec_type   sum_ff;
   qafm_pkg::sum_vec_type   sum_in;
   logic                    out_v_ff;
   qafm_pkg::motor_vec_type motor_ff;
   qafm_pkg::motor_vec_type motor_in;
   logic                    ax_ready;
   logic                    sum_ready;
   logic                    out_ready;
   logic signed [qafm_pkg::SumW-1:0] base_ext;
   logic signed [qafm_pkg::SumW-1:0] ax_ext [qafm_pkg::NumAxis];

   assign out_ready  = !out_v_ff || rsp.ready;
   assign sum_ready  = !sum_v_ff || out_ready;
   assign ax_ready   = !ax_v_ff || sum_ready;
   assign prod_ready = ax_ready;

   always_comb begin
      ax_in[qafm_pkg::AxRoll]  = $signed(prod_data[qafm_pkg::ErrRollAngle])
                               + ($signed(prod_data[qafm_pkg::ErrRollRate]) <<< qafm_pkg::RateShift);
      ax_in[qafm_pkg::AxPitch] = $signed(prod_data[qafm_pkg::ErrPitchAngle])
                               + ($signed(prod_data[qafm_pkg::ErrPitchRate]) <<< qafm_pkg::RateShift);
      ax_in[qafm_pkg::AxYaw]   = $signed(prod_data[qafm_pkg::ErrYawAngle])
                               + ($signed(prod_data[qafm_pkg::ErrYawRate]) <<< qafm_pkg::RateShift);
   end

   assign base_ext = {{(qafm_pkg::SumW - qafm_pkg::BaseW - qafm_pkg::BaseShift){1'b0}},
                      cfg.base_thrust, {qafm_pkg::BaseShift{1'b0}}};

   for (genvar a = 0; a < qafm_pkg::NumAxis; a++) begin : g_ax
      assign ax_ext[a] = qafm_pkg::SumW'($signed(ax_ff[a]));
   end

   always_comb begin
      for (int m = 0; m < qafm_pkg::NumMotor; m++) begin
         sum_in[m] = base_ext;
         for (int a = 0; a < qafm_pkg::NumAxis; a++) begin
            sum_in[m] = qafm_pkg::MixPlus[m][a] ? sum_in[m] + ax_ext[a]
                                                : sum_in[m] - ax_ext[a];
         end
      end
   end

   always_comb begin
      for (int m = 0; m < qafm_pkg::NumMotor; m++) begin
         if (sum_ff[m][qafm_pkg::SumW-1]) begin
            motor_in[m] = '0;
         end else if (|sum_ff[m][qafm_pkg::SumW-2:TopW]) begin
            motor_in[m] = '1;
         end else begin
            motor_in[m] = sum_ff[m][TopW-1:qafm_pkg::FracW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_v_ff  <= 1'b0;
         sum_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (ax_ready) begin
            ax_v_ff <= prod_valid;
         end
         if (sum_ready) begin
            sum_v_ff <= ax_v_ff;
         end
         if (out_ready) begin
            out_v_ff <= sum_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_valid && ax_ready) begin
         ax_ff <= ax_in;
      end
      if (ax_v_ff && sum_ready) begin
         sum_ff <= sum_in;
      end
      if (sum_v_ff && out_ready) begin
         motor_ff <= motor_in;
      end
   end

   assign rsp.valid       = out_v_ff;
   assign rsp.motor_one   = motor_ff[0];
   assign rsp.motor_two   = motor_ff[1];
   assign rsp.motor_three = motor_ff[2];
   assign rsp.motor_four  = motor_ff[3];

   a_neg_sum_zero : assert property (@(posedge clock) disable iff (reset)
      (sum_v_ff && out_ready && sum_ff[0][qafm_pkg::SumW-1]) |=> (rsp.motor_one == '0))
      else $error("negative sum did not give a zero command");

   a_big_sum_sat : assert property (@(posedge clock) disable iff (reset)
      (sum_v_ff && out_ready && !sum_ff[3][qafm_pkg::SumW-1]
       && (|sum_ff[3][qafm_pkg::SumW-2:TopW])) |=> (rsp.motor_four == '1))
      else $error("oversized sum did not saturate");

   a_sum_advances : assert property (@(posedge clock) disable iff (reset)
      (sum_v_ff && !out_v_ff) |=> out_v_ff)
      else $error("finished sum not moved into an empty output register");

endmodule

`default_nettype wire

>>> rtl/core/quadrotor_attitude_feedback_mixer_core.sv
// Quadrotor attitude state-feedback controller with four-motor mixing.
//
// req_chan carries one sensor transaction: roll and pitch references, yaw-rate
// reference, three attitude estimates and three gyro rates. rsp_chan returns
// one transaction of four clamped motor commands for every request, in order.
// csr_chan writes the six gains and the base thrust; write only while idle.
// Writes to an index past the base thrust register are dropped.
//
// Pipeline: the response is registered through the error, product, axis sum,
// motor sum and clamp registers. Throughput: one transaction per cycle while
// rsp_chan does not stall, through the five-register valid/ready pipeline.
// Each register takes new data whenever it is empty or its successor moves,
// so requests keep being accepted while a response waits and empty stages
// remain.
//
// Reset clears every pipeline valid and loads the default gains and thrust.
// When rsp_chan stalls, the pipeline fills and then req_chan.ready drops;
// nothing is lost or repeated.
`default_nettype none

module quadrotor_attitude_feedback_mixer_core (
   input  wire logic  clock,
   input  wire logic  reset,
   qafm_req_if.sink   req_chan,
   qafm_rsp_if.source rsp_chan,
   qafm_csr_if.sink   csr_chan
);

   qafm_pkg::cfg_type      cfg;
   logic                   err_valid;
   logic                   err_ready;
   qafm_pkg::err_vec_type  err_data;
   logic                   prod_valid;
   logic                   prod_ready;
   qafm_pkg::prod_vec_type prod_data;

   qafm_csr_regs u_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .cfg   (cfg)
   );

   qafm_err_stage u_err (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .err_valid (err_valid),
      .err_ready (err_ready),
      .err_data  (err_data)
   );

   qafm_mul_stage u_mul (
      .clock      (clock),
      .reset      (reset),
      .err_valid  (err_valid),
      .err_ready  (err_ready),
      .err_data   (err_data),
      .cfg        (cfg),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod_data  (prod_data)
   );

   qafm_mix_stage u_mix (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod_data  (prod_data),
      .cfg        (cfg),
      .rsp        (rsp_chan)
   );

   a_stall_backs_up : assert property (@(posedge clock) disable iff (reset)
      (prod_valid && !prod_ready) |-> !err_ready)
      else $error("product stage stalled but error stage still advancing");

endmodule

`default_nettype wire

>>> tb/qafm_tb_pkg.sv
// Transaction types, register defaults and the motor command scoreboard for the mixer bench.
package qafm_tb_pkg;
   import qafm_pkg::*;

   localparam int NumRegs     = 7;
   localparam int RateScale   = 2;
   localparam int ThrustScale = 12;
   localparam int MotorMax    = 65535;
   localparam int MaxReports  = 10;

   localparam logic [RegIdxW-1:0] RegUnused = 3'd7;

   localparam logic [CsrDataW-1:0] RegDefault [NumRegs] = '{
      24'd34582, 24'd35987, 24'd1256, 24'd4908, 24'd5626, 24'd4324, 24'd7549747
   };

   // bit k set: error term k is added for that motor, otherwise subtracted
   localparam logic [NumErr-1:0] MotorAddMask [NumMotor] = '{
      6'b000000, 6'b110110, 6'b011011, 6'b101101
   };

   typedef struct packed {
      logic signed [InW-1:0] roll_ref;
      logic signed [InW-1:0] pitch_ref;
      logic signed [InW-1:0] yaw_rate_ref;
      logic signed [InW-1:0] roll_angle;
      logic signed [InW-1:0] pitch_angle;
      logic signed [InW-1:0] yaw_angle;
      logic signed [InW-1:0] roll_rate;
      logic signed [InW-1:0] pitch_rate;
      logic signed [InW-1:0] yaw_rate;
   } sensor_type;

   typedef struct packed {
      logic [MotorW-1:0] motor_one;
      logic [MotorW-1:0] motor_two;
      logic [MotorW-1:0] motor_three;
      logic [MotorW-1:0] motor_four;
   } motor_type;

   class mixer_scoreboard;
      logic [CsrDataW-1:0] reg_value [NumRegs];
      motor_type           motor_cmd_q [$];
      int                  mismatch_count;

      function new();
         reg_value      = RegDefault;
         mismatch_count = 0;
      endfunction

      function void set_register(logic [RegIdxW-1:0] idx, logic [CsrDataW-1:0] value);
         if (idx == RegBaseThrust) begin
            reg_value[idx] = value;
         end else if (idx < RegBaseThrust) begin
            reg_value[idx] = CsrDataW'(value[GainW-1:0]);
         end
      endfunction

      function motor_type predict_motors(sensor_type s);
         logic signed [ErrW-1:0]  err [NumErr];
         logic signed [SumW-1:0]  term [NumErr];
         logic signed [SumW-1:0]  err_w;
         logic signed [SumW-1:0]  gain_w;
         logic signed [SumW-1:0]  total;
         logic [MotorW-1:0]       cmd [NumMotor];
         int                      k;
         int                      m;
         err[ErrRollAngle]  = s.roll_ref - s.roll_angle;
         err[ErrPitchAngle] = s.pitch_ref - s.pitch_angle;
         err[ErrYawAngle]   = -s.yaw_angle;
         err[ErrRollRate]   = -s.roll_rate;
         err[ErrPitchRate]  = -s.pitch_rate;
         err[ErrYawRate]    = s.yaw_rate_ref - s.yaw_rate;
         for (k = 0; k < NumErr; k++) begin
            err_w   = err[k];
            gain_w  = SumW'(reg_value[k][GainW-1:0]);
            term[k] = err_w * gain_w;
            if (k >= ErrRollRate) begin
               term[k] = term[k] <<< RateScale;
            end
         end
         for (m = 0; m < NumMotor; m++) begin
            total = SumW'(reg_value[RegBaseThrust]) <<< ThrustScale;
            for (k = 0; k < NumErr; k++) begin
               if (MotorAddMask[m][k]) begin
                  total = total + term[k];
               end else begin
                  total = total - term[k];
               end
            end
            if (total < 0) begin
               cmd[m] = '0;
            end else if (total[SumW-1:FracW] > MotorMax) begin
               cmd[m] = MotorW'(MotorMax);
            end else begin
               cmd[m] = total[FracW+MotorW-1:FracW];
            end
         end
         return '{cmd[0], cmd[1], cmd[2], cmd[3]};
      endfunction

      function void note_request(sensor_type s);
         motor_cmd_q.push_back(predict_motors(s));
      endfunction

      function int pending();
         return motor_cmd_q.size();
      endfunction

      function void check_response(motor_type got);
         motor_type want;
         if (motor_cmd_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MaxReports) begin
               $display("%0t: motor transaction with none outstanding: %0d %0d %0d %0d", $time,
                        got.motor_one, got.motor_two, got.motor_three, got.motor_four);
            end
            return;
         end
         want = motor_cmd_q.pop_front();
         if (got.motor_one !== want.motor_one || got.motor_two !== want.motor_two ||
             got.motor_three !== want.motor_three || got.motor_four !== want.motor_four) begin
            mismatch_count++;
            if (mismatch_count <= MaxReports) begin
               $display("%0t: motor commands differ: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                        $time, want.motor_one, want.motor_two, want.motor_three, want.motor_four,
                        got.motor_one, got.motor_two, got.motor_three, got.motor_four);
            end
         end
      endfunction
   endclass

endpackage

>>> tb/tb_top.sv
// Top-level bench for the attitude mixer: clock, reset, drivers, monitors and phase sequence.
module tb_top;
   import qafm_pkg::*;
   import qafm_tb_pkg::*;

   localparam int NumPhases     = 6;
   localparam int PressurePhase = 4;
   localparam int ItemsPerPhase = 215;
   localparam int NumDirected   = 22;
   localparam int DrainCycles   = 12;
   localparam int HoldCycles    = 200;
   localparam int CycleLimit    = 200000;
   localparam int IdlePct  [NumPhases] = '{0, 83, 0, 25, 0, 25};
   localparam int StallPct [NumPhases] = '{0, 0, 83, 25, 0, 25};

   localparam logic signed [InW-1:0] FieldMax = 16'sh7FFF;
   localparam logic signed [InW-1:0] FieldMin = 16'sh8000;

   logic clock;
   logic reset;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_trigger   = 1'b0;
   bit hold_seen      = 1'b0;
   int hold_left      = 0;
   int cycle_count    = 0;

   mixer_scoreboard scoreboard;

   qafm_req_if req_chan ();
   qafm_rsp_if rsp_chan ();
   qafm_csr_if csr_chan ();

   quadrotor_attitude_feedback_mixer_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [InW-1:0] rand_field();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
         return InW'($urandom);
      end else if (pick < 75) begin
         return InW'(int'($urandom_range(0, 1024)) - 512);
      end else if (pick < 88) begin
         return InW'(int'($urandom_range(0, 16384)) - 8192);
      end
      case ($urandom_range(3))
         0: return FieldMax;
         1: return FieldMin;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   function automatic logic signed [InW-1:0] rand_offset();
      return InW'(int'($urandom_range(0, 64)) - 32);
   endfunction

   function automatic sensor_type rand_sensor();
      sensor_type s;
      s.roll_ref     = rand_field();
      s.pitch_ref    = rand_field();
      s.yaw_rate_ref = rand_field();
      s.roll_angle   = rand_field();
      s.pitch_angle  = rand_field();
      s.yaw_angle    = rand_field();
      s.roll_rate    = rand_field();
      s.pitch_rate   = rand_field();
      s.yaw_rate     = rand_field();
      // for some requests keep estimates near their references so more commands land inside the range
      if ($urandom_range(99) < 40) begin
         s.roll_angle  = s.roll_ref + rand_offset();
         s.pitch_angle = s.pitch_ref + rand_offset();
         s.yaw_rate    = s.yaw_rate_ref + rand_offset();
      end
      return s;
   endfunction

   task automatic send_request(input sensor_type s);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid        <= 1'b1;
      req_chan.roll_ref     <= s.roll_ref;
      req_chan.pitch_ref    <= s.pitch_ref;
      req_chan.yaw_rate_ref <= s.yaw_rate_ref;
      req_chan.roll_angle   <= s.roll_angle;
      req_chan.pitch_angle  <= s.pitch_angle;
      req_chan.yaw_angle    <= s.yaw_angle;
      req_chan.roll_rate    <= s.roll_rate;
      req_chan.pitch_rate   <= s.pitch_rate;
      req_chan.yaw_rate     <= s.yaw_rate;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic write_register(input logic [RegIdxW-1:0] idx,
                                 input logic [CsrDataW-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         scoreboard.note_request('{req_chan.roll_ref, req_chan.pitch_ref, req_chan.yaw_rate_ref,
                                   req_chan.roll_angle, req_chan.pitch_angle, req_chan.yaw_angle,
                                   req_chan.roll_rate, req_chan.pitch_rate, req_chan.yaw_rate});
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         scoreboard.check_response('{rsp_chan.motor_one, rsp_chan.motor_two,
                                     rsp_chan.motor_three, rsp_chan.motor_four});
      end
      if (!reset && csr_chan.valid && csr_chan.ready) begin
         scoreboard.set_register(csr_chan.index, csr_chan.data);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen      <= hold_trigger;
         hold_left      <= HoldCycles;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      sensor_type s;
      int         phase;
      int         n;
      int         r;
      scoreboard            = new();
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.roll_ref     = '0;
      req_chan.pitch_ref    = '0;
      req_chan.yaw_rate_ref = '0;
      req_chan.roll_angle   = '0;
      req_chan.pitch_angle  = '0;
      req_chan.yaw_angle    = '0;
      req_chan.roll_rate    = '0;
      req_chan.pitch_rate   = '0;
      req_chan.yaw_rate     = '0;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = '0;
      csr_chan.data         = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < NumPhases; phase++) begin
         case (phase)
            1: begin
               for (r = RegGainRollAngle; r <= RegGainYawRate; r++) begin
                  write_register(RegIdxW'(r), CsrDataW'(16'hFFFF));
               end
               write_register(RegBaseThrust, 24'hFFFFFF);
            end
            2: begin
               for (r = RegGainRollAngle; r <= RegBaseThrust; r++) begin
                  write_register(RegIdxW'(r), '0);
               end
               write_register(RegUnused, 24'hFFFFFF);
            end
            3: begin
               for (r = RegGainRollAngle; r <= RegGainYawRate; r++) begin
                  write_register(RegIdxW'(r), CsrDataW'($urandom_range(0, 16'hFFFF)));
               end
               write_register(RegBaseThrust, CsrDataW'($urandom_range(0, 24'hFFFFFF)));
            end
            4: begin
               for (r = RegGainRollAngle; r <= RegGainYawRate; r++) begin
                  write_register(RegIdxW'(r), CsrDataW'($urandom_range(0, 1023)));
               end
               write_register(RegBaseThrust, 24'd16776960);
            end
            5: begin
               for (r = RegGainRollAngle; r <= RegBaseThrust; r++) begin
                  write_register(RegIdxW'(r), RegDefault[r]);
               end
               write_register(RegUnused, '0);
            end
            default: ;
         endcase
         csr_chan.valid <= 1'b0;
         send_idle_pct  = IdlePct[phase];
         recv_stall_pct = StallPct[phase];

         if (phase == 0) begin
            for (n = 0; n < NumDirected; n++) begin
               s = '0;
               case (n)
                  1: s = {9{FieldMax}};
                  2: s = {9{FieldMin}};
                  3: begin s.roll_ref = FieldMax; s.roll_angle = FieldMin; end
                  4: begin s.roll_ref = FieldMin; s.roll_angle = FieldMax; end
                  5: begin s.pitch_ref = FieldMax; s.pitch_angle = FieldMin; end
                  6: begin s.pitch_ref = FieldMin; s.pitch_angle = FieldMax; end
                  7: s.yaw_angle = FieldMin;
                  8: s.yaw_angle = FieldMax;
                  9: s.roll_rate = FieldMin;
                  10: s.roll_rate = FieldMax;
                  11: s.pitch_rate = FieldMin;
                  12: s.pitch_rate = FieldMax;
                  13: begin s.yaw_rate_ref = FieldMax; s.yaw_rate = FieldMin; end
                  14: begin s.yaw_rate_ref = FieldMin; s.yaw_rate = FieldMax; end
                  15: s.roll_ref = 16'sd100;
                  16: s = '1;
                  17: s.roll_ref = 16'sd1;
                  18: s.roll_angle = 16'sd1;
                  19: s.yaw_rate_ref = FieldMax;
                  20: s.pitch_ref = FieldMin;
                  21: begin s.yaw_rate = 16'sd3; s.pitch_rate = -16'sd7; end
                  default: ;
               endcase
               send_request(s);
            end
         end

         if (phase == PressurePhase) begin
            hold_trigger <= ~hold_trigger;
         end
         for (n = 0; n < ItemsPerPhase; n++) begin
            send_request(rand_sensor());
         end
         req_chan.valid <= 1'b0;
         while (scoreboard.pending() != 0) @(posedge clock);
         repeat (DrainCycles) @(posedge clock);
      end

      if (scoreboard.mismatch_count == 0 && scoreboard.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
